// ===== rtl/joystick_deadzone_scale_to_keys_top_macros.svh =====
// Assertion macros for the joystick conditioning block.
// Used by the top level only; each macro expects aclk and aresetn in scope.
`ifndef JOYSTICK_DEADZONE_SCALE_TO_KEYS_TOP_MACROS_SVH
`define JOYSTICK_DEADZONE_SCALE_TO_KEYS_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define JDSK_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define JDSK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/jdsk_pkg.sv =====
// Package of the joystick conditioning block: constants, codes, shared types
// and the output saturation function. No dependencies.
`timescale 1ns / 1ps

package jdsk_pkg;

    localparam int OUT_MIN     = -127;
    localparam int OUT_MAX     = 127;
    localparam int FIXED_SCALE = 256;
    localparam int SAMPLE_BITS = 10;
    localparam int SCALE_SHIFT = $clog2(FIXED_SCALE);

    localparam int RAW_W       = 10;
    localparam int CTR_W       = RAW_W + 1;
    localparam int GAIN_W      = 16;
    localparam int PROD_W      = CTR_W + GAIN_W + 1;
    localparam int SQ_W        = 2 * RAW_W;
    localparam int AXIS_W      = 8;
    localparam int ACT_W       = 7;
    localparam int MAX_RESULTS = 4;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int PTR_W       = $clog2(MAX_RESULTS);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [RAW_W-1:0] SAMPLE_MASK = RAW_W'((64'd1 << SAMPLE_BITS) - 64'd1);

    localparam logic signed [PROD_W-1:0] OUT_MIN_P = PROD_W'(OUT_MIN);
    localparam logic signed [PROD_W-1:0] OUT_MAX_P = PROD_W'(OUT_MAX);
    localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(FIXED_SCALE - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NEUTRAL_X      = 3'd0,
        REG_NEUTRAL_Y      = 3'd1,
        REG_INNER_DEADZONE = 3'd2,
        REG_GAIN           = 3'd3,
        REG_ACTUATION      = 3'd4,
        REG_ORIENTATION    = 3'd5,
        REG_STICK_MODE     = 3'd6
    } reg_idx_t;

    typedef enum logic [1:0] {
        KIND_AXIS    = 2'd0,
        KIND_PRESS   = 2'd1,
        KIND_RELEASE = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_RIGHT = 2'd3
    } dir_t;

    typedef enum logic [1:0] {
        MODE_ANALOG  = 2'd0,
        MODE_LETTERS = 2'd1,
        MODE_ARROWS  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ORIENT_UP    = 2'd0,
        ORIENT_RIGHT = 2'd1,
        ORIENT_DOWN  = 2'd2,
        ORIENT_LEFT  = 2'd3
    } orient_t;

    typedef enum logic [1:0] {
        LVL_CENTER = 2'd0,
        LVL_POS    = 2'd1,
        LVL_NEG    = 2'd2
    } lvl_t;

    typedef struct packed {
        logic en_a;
        logic en_b;
        logic en_c;
    } lane_ctrl_t;

    typedef struct packed {
        logic [CNT_W-1:0]                cnt;
        kind_t [MAX_RESULTS-1:0]         kind;
        dir_t [MAX_RESULTS-1:0]          dir;
        logic signed [AXIS_W-1:0]        ax;
        logic signed [AXIS_W-1:0]        ay;
        logic                            key_set;
    } batch_t;

    function automatic logic signed [AXIS_W-1:0] sat_out(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] r;
        if (v < OUT_MIN_P) begin
            r = OUT_MIN_P;
        end else if (v > OUT_MAX_P) begin
            r = OUT_MAX_P;
        end else begin
            r = v;
        end
        return r[AXIS_W-1:0];
    endfunction

endpackage

// ===== rtl/joystick_deadzone_scale_to_keys_top.sv =====
// An item passes stages A, B and C, then the result bank offers its first result.
// Throughput, while m_ready stays high: one item per cycle while each gives at most one
// result; an item with n results holds the single result register bank until all n are
// taken, one result a cycle.
// Reset (aresetn low, synchronous) empties the pipeline and the result bank,
// centers both key levels and loads the reset values of all registers.
`timescale 1ns / 1ps
`include "joystick_deadzone_scale_to_keys_top_macros.svh"

module joystick_deadzone_scale_to_keys_top import jdsk_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [RAW_W-1:0]          s_raw_x,
    input  logic [RAW_W-1:0]          s_raw_y,

    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_kind,
    output logic signed [AXIS_W-1:0]  m_axis_x,
    output logic signed [AXIS_W-1:0]  m_axis_y,
    output logic [1:0]                m_key_dir,
    output logic                      m_key_set,
    output logic                      m_last
);

    // Configuration registers. Writes are taken in every cycle; the block
    // relies on them arriving only while no item is in flight.
    logic [RAW_W-1:0]  neutral_x_reg;
    logic [RAW_W-1:0]  neutral_y_reg;
    logic [RAW_W-1:0]  inner_dz_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [ACT_W-1:0]  act_reg;
    logic [1:0]        orient_reg;
    logic [1:0]        mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            neutral_x_reg <= RAW_W'(512);
            neutral_y_reg <= RAW_W'(512);
            inner_dz_reg  <= '0;
            gain_reg      <= GAIN_W'(256);
            act_reg       <= ACT_W'(64);
            orient_reg    <= ORIENT_UP;
            mode_reg      <= MODE_ANALOG;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_NEUTRAL_X:      neutral_x_reg <= cfg_data[RAW_W-1:0];
                REG_NEUTRAL_Y:      neutral_y_reg <= cfg_data[RAW_W-1:0];
                REG_INNER_DEADZONE: inner_dz_reg  <= cfg_data[RAW_W-1:0];
                REG_GAIN:           gain_reg      <= cfg_data[GAIN_W-1:0];
                REG_ACTUATION:      act_reg       <= cfg_data[ACT_W-1:0];
                REG_ORIENTATION:    orient_reg    <= cfg_data[1:0];
                REG_STICK_MODE:     mode_reg      <= cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    // Pipeline control. Stage A holds the centered samples, stage B the gain
    // products and squares, stage C the scaled axes and the deadzone verdict.
    // Each stage advances when the one after it is empty or moving on, so a
    // new item enters every cycle unless the result bank is still busy.
    logic       v_a_reg, v_a_next;
    logic       v_b_reg, v_b_next;
    logic       v_c_reg, v_c_next;
    logic       seq_free;
    logic       load;
    lane_ctrl_t ctrl;

    assign load      = v_c_reg && seq_free;
    assign ctrl.en_c = v_b_reg && (!v_c_reg || load);
    assign ctrl.en_b = v_a_reg && (!v_b_reg || ctrl.en_c);
    assign s_ready   = !v_a_reg || ctrl.en_b;
    assign ctrl.en_a = s_valid && s_ready;

    always_comb begin
        v_a_next = ctrl.en_a ? 1'b1 : (ctrl.en_b ? 1'b0 : v_a_reg);
        v_b_next = ctrl.en_b ? 1'b1 : (ctrl.en_c ? 1'b0 : v_b_reg);
        v_c_next = ctrl.en_c ? 1'b1 : (load ? 1'b0 : v_c_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_a_reg <= 1'b0;
            v_b_reg <= 1'b0;
            v_c_reg <= 1'b0;
        end else begin
            v_a_reg <= v_a_next;
            v_b_reg <= v_b_next;
            v_c_reg <= v_c_next;
        end
    end

    // The two axis lanes run side by side on the horizontal and vertical sample.
    logic [SQ_W-1:0]          sq_x, sq_y;
    logic signed [AXIS_W-1:0] sc_x, sc_y;

    jdsk_lane u_lane_x (
        .aclk    (aclk),
        .ctrl    (ctrl),
        .raw     (s_raw_x),
        .neutral (neutral_x_reg),
        .gain    (gain_reg),
        .sq      (sq_x),
        .scaled  (sc_x)
    );

    jdsk_lane u_lane_y (
        .aclk    (aclk),
        .ctrl    (ctrl),
        .raw     (s_raw_y),
        .neutral (neutral_y_reg),
        .gain    (gain_reg),
        .sq      (sq_y),
        .scaled  (sc_y)
    );

    // Squared deadzone radius is formed beside the lane squares, and the
    // radius test uses both lanes' squares in the next stage.
    logic [SQ_W-1:0] dzsq_reg, dzsq_next;
    logic            below_reg, below_next;

    assign dzsq_next  = SQ_W'(inner_dz_reg) * SQ_W'(inner_dz_reg);
    assign below_next = (({1'b0, sq_x} + {1'b0, sq_y}) < {1'b0, dzsq_reg});

    always_ff @(posedge aclk) begin
        if (ctrl.en_b) begin
            dzsq_reg <= dzsq_next;
        end
        if (ctrl.en_c) begin
            below_reg <= below_next;
        end
    end

    // The merge stage combines both lanes into the result list of the sample.
    batch_t batch;

    jdsk_merge u_merge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (load),
        .sx      (sc_x),
        .sy      (sc_y),
        .below   (below_reg),
        .act     (act_reg),
        .orient  (orient_reg),
        .mode    (mode_reg),
        .batch   (batch)
    );

    // The sequencer presents the stored list one result at a time. An item
    // with no result loads an empty list and leaves nothing behind.
    jdsk_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (load),
        .batch_in    (batch),
        .free        (seq_free),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .out_kind    (m_kind),
        .out_axis_x  (m_axis_x),
        .out_axis_y  (m_axis_y),
        .out_key_dir (m_key_dir),
        .out_key_set (m_key_set),
        .out_last    (m_last)
    );

    // Input is held off only when the first stage is occupied and stuck.
    `JDSK_ASSERT_NOW(a_ready_full, !s_ready, v_a_reg, "input stalled with empty first stage")
    // An axis report is always the only result of its sample.
    `JDSK_ASSERT_NOW(a_axis_last, m_valid && (m_kind == KIND_AXIS), m_last, "axis report not last")
    // Key events carry zero axis values.
    `JDSK_ASSERT_NOW(a_key_zero, m_valid && (m_kind != KIND_AXIS),
        (m_axis_x == '0) && (m_axis_y == '0), "key event with nonzero axes")
    // A finished sample waiting for the sequencer is not lost.
    `JDSK_ASSERT_NEXT(a_hold_c, v_c_reg && !seq_free, v_c_reg, "stage C item dropped")

endmodule

// ===== rtl/jdsk_lane.sv =====
// One axis lane: centering, gain multiply and square, scaling with saturation.
// Depends on jdsk_pkg.
`timescale 1ns / 1ps

module jdsk_lane import jdsk_pkg::*; (
    input  logic                       aclk,
    input  lane_ctrl_t                 ctrl,
    input  logic [RAW_W-1:0]           raw,
    input  logic [RAW_W-1:0]           neutral,
    input  logic [GAIN_W-1:0]          gain,
    output logic [SQ_W-1:0]            sq,
    output logic signed [AXIS_W-1:0]   scaled
);

    logic signed [CTR_W-1:0]   ctr_reg, ctr_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic [SQ_W-1:0]           sq_reg, sq_next;
    logic signed [AXIS_W-1:0]  scaled_reg, scaled_next;
    logic signed [2*CTR_W-1:0] sq_full;
    logic signed [PROD_W-1:0]  biased;
    logic signed [PROD_W-1:0]  shifted;

    assign ctr_next = $signed({1'b0, raw & SAMPLE_MASK}) - $signed({1'b0, neutral & SAMPLE_MASK});

    assign prod_next = PROD_W'(ctr_reg) * PROD_W'($signed({1'b0, gain}));
    assign sq_full   = (2*CTR_W)'(ctr_reg) * (2*CTR_W)'(ctr_reg);
    assign sq_next   = sq_full[SQ_W-1:0];

    // Biasing a negative product before the shift makes the division truncate toward zero.
    assign biased      = prod_reg + (prod_reg[PROD_W-1] ? ROUND_BIAS : '0);
    assign shifted     = biased >>> SCALE_SHIFT;
    assign scaled_next = sat_out(shifted);

    always_ff @(posedge aclk) begin
        if (ctrl.en_a) begin
            ctr_reg <= ctr_next;
        end
        if (ctrl.en_b) begin
            prod_reg <= prod_next;
            sq_reg   <= sq_next;
        end
        if (ctrl.en_c) begin
            scaled_reg <= scaled_next;
        end
    end

    assign sq     = sq_reg;
    assign scaled = scaled_reg;

endmodule

// ===== rtl/jdsk_merge.sv =====
// Merge stage: deadzone, rotation, key levels and the event list of one sample.
// Holds the previous key levels. Depends on jdsk_pkg.
`timescale 1ns / 1ps

module jdsk_merge import jdsk_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      load,
    input  logic signed [AXIS_W-1:0]  sx,
    input  logic signed [AXIS_W-1:0]  sy,
    input  logic                      below,
    input  logic [ACT_W-1:0]          act,
    input  logic [1:0]                orient,
    input  logic [1:0]                mode,
    output batch_t                    batch
);

    lvl_t prev_v_reg, prev_v_next;
    lvl_t prev_h_reg, prev_h_next;

    logic signed [AXIS_W:0]   xs, ys, rx9, ry9;
    logic signed [AXIS_W-1:0] rx, ry;
    lvl_t                     vy, vx;
    logic                     key_mode;

    function automatic lvl_t lvl_of(input logic signed [AXIS_W-1:0] v,
                                    input logic [ACT_W-1:0] a);
        logic signed [AXIS_W+1:0] ve;
        logic signed [AXIS_W+1:0] ae;
        lvl_t l;
        ve = (AXIS_W+2)'(v);
        ae = $signed({3'b000, a});
        if (ve > ae) begin
            l = LVL_POS;
        end else if (ve < -ae) begin
            l = LVL_NEG;
        end else begin
            l = LVL_CENTER;
        end
        return l;
    endfunction

    assign xs = below ? '0 : (AXIS_W+1)'(sx);
    assign ys = below ? '0 : (AXIS_W+1)'(sy);

    always_comb begin
        unique case (orient)
            ORIENT_RIGHT: begin rx9 = ys;  ry9 = -xs; end
            ORIENT_DOWN:  begin rx9 = -xs; ry9 = -ys; end
            ORIENT_LEFT:  begin rx9 = -ys; ry9 = xs;  end
            default:      begin rx9 = xs;  ry9 = ys;  end
        endcase
    end

    assign rx = sat_out(PROD_W'(rx9));
    assign ry = sat_out(PROD_W'(ry9));
    assign vy = lvl_of(ry, act);
    assign vx = lvl_of(rx, act);
    assign key_mode = (mode == MODE_LETTERS) || (mode == MODE_ARROWS);

    // Vertical changes are listed first; a level change releases the old key
    // before pressing the new one.
    always_comb begin
        logic [CNT_W-1:0] k;
        k = '0;
        batch.cnt     = '0;
        batch.ax      = '0;
        batch.ay      = '0;
        batch.key_set = 1'b0;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            batch.kind[i] = KIND_AXIS;
            batch.dir[i]  = DIR_UP;
        end
        if (mode == MODE_ANALOG) begin
            batch.cnt = CNT_W'(1);
            batch.ax  = rx;
            batch.ay  = ry;
        end else if (key_mode) begin
            batch.key_set = (mode == MODE_ARROWS);
            if (vy != prev_v_reg) begin
                if (prev_v_reg != LVL_CENTER) begin
                    batch.kind[k[PTR_W-1:0]] = KIND_RELEASE;
                    batch.dir[k[PTR_W-1:0]]  = (prev_v_reg == LVL_POS) ? DIR_UP : DIR_DOWN;
                    k = k + CNT_W'(1);
                end
                if (vy != LVL_CENTER) begin
                    batch.kind[k[PTR_W-1:0]] = KIND_PRESS;
                    batch.dir[k[PTR_W-1:0]]  = (vy == LVL_POS) ? DIR_UP : DIR_DOWN;
                    k = k + CNT_W'(1);
                end
            end
            if (vx != prev_h_reg) begin
                if (prev_h_reg != LVL_CENTER) begin
                    batch.kind[k[PTR_W-1:0]] = KIND_RELEASE;
                    batch.dir[k[PTR_W-1:0]]  = (prev_h_reg == LVL_POS) ? DIR_RIGHT : DIR_LEFT;
                    k = k + CNT_W'(1);
                end
                if (vx != LVL_CENTER) begin
                    batch.kind[k[PTR_W-1:0]] = KIND_PRESS;
                    batch.dir[k[PTR_W-1:0]]  = (vx == LVL_POS) ? DIR_RIGHT : DIR_LEFT;
                    k = k + CNT_W'(1);
                end
            end
            batch.cnt = k;
        end
    end

    always_comb begin
        prev_v_next = prev_v_reg;
        prev_h_next = prev_h_reg;
        if (load && key_mode) begin
            prev_v_next = vy;
            prev_h_next = vx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_v_reg <= LVL_CENTER;
            prev_h_reg <= LVL_CENTER;
        end else begin
            prev_v_reg <= prev_v_next;
            prev_h_reg <= prev_h_next;
        end
    end

endmodule

// ===== rtl/jdsk_seq.sv =====
// Result sequencer: holds the event list of one sample and hands out one
// result per accepted transfer. Depends on jdsk_pkg.
`timescale 1ns / 1ps

module jdsk_seq import jdsk_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      load,
    input  batch_t                    batch_in,
    output logic                      free,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [1:0]                out_kind,
    output logic signed [AXIS_W-1:0]  out_axis_x,
    output logic signed [AXIS_W-1:0]  out_axis_y,
    output logic [1:0]                out_key_dir,
    output logic                      out_key_set,
    output logic                      out_last
);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    batch_t           batch_reg;
    logic             pop;
    logic             at_last;

    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid && out_ready;
    assign at_last   = ((CNT_W'(ptr_reg) + CNT_W'(1)) == cnt_reg);
    assign free      = !out_valid || (pop && at_last);

    always_comb begin
        cnt_next = cnt_reg;
        ptr_next = ptr_reg;
        if (load) begin
            cnt_next = batch_in.cnt;
            ptr_next = '0;
        end else if (pop) begin
            if (at_last) begin
                cnt_next = '0;
                ptr_next = '0;
            end else begin
                ptr_next = ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            ptr_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            ptr_reg <= ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            batch_reg <= batch_in;
        end
    end

    assign out_kind    = batch_reg.kind[ptr_reg];
    assign out_key_dir = batch_reg.dir[ptr_reg];
    assign out_axis_x  = batch_reg.ax;
    assign out_axis_y  = batch_reg.ay;
    assign out_key_set = batch_reg.key_set;
    assign out_last    = at_last;

endmodule

// ===== dv/joystick_deadzone_scale_to_keys_top_tb.sv =====
// Self-checking testbench for joystick_deadzone_scale_to_keys_top: random and
// directed samples under changing settings, checked against an in-bench model.
// Depends on jdsk_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module joystick_deadzone_scale_to_keys_top_tb;
    import jdsk_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int IDLE_LIMIT    = 3000;
    localparam int RANDOM_ITEMS  = 245;
    localparam int MAX_REPORTS   = 10;

    // Mode code 3 is not a named mode; the block must ignore samples under it.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct {
        kind_t                    kind;
        logic signed [AXIS_W-1:0] ax;
        logic signed [AXIS_W-1:0] ay;
        dir_t                     dir;
        logic                     arrows;
        logic                     last;
    } stick_event_t;

    // Holds a copy of the register file and the key levels, turns every accepted
    // sample into the events the block should send, and checks them in order.
    class stick_scoreboard;
        logic [RAW_W-1:0]  neutral_x;
        logic [RAW_W-1:0]  neutral_y;
        logic [RAW_W-1:0]  deadzone;
        logic [GAIN_W-1:0] gain;
        logic [ACT_W-1:0]  act;
        logic [1:0]        orient;
        logic [1:0]        mode;
        lvl_t              vert_lvl;
        lvl_t              horiz_lvl;
        stick_event_t      expected_events[$];
        int                failures;
        int                samples;
        int                reports;
        int                presses;
        int                releases;

        function new();
            neutral_x = 10'd512;
            neutral_y = 10'd512;
            deadzone  = '0;
            gain      = 16'd256;
            act       = 7'd64;
            orient    = ORIENT_UP;
            mode      = MODE_ANALOG;
            vert_lvl  = LVL_CENTER;
            horiz_lvl = LVL_CENTER;
            failures  = 0;
            samples   = 0;
            reports   = 0;
            presses   = 0;
            releases  = 0;
        endfunction

        function int pending();
            return expected_events.size();
        endfunction

        function void report(string msg);
            failures++;
            if (failures <= MAX_REPORTS) begin
                $display("ERROR @%0t: %s", $realtime, msg);
            end
        endfunction

        function void apply_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_NEUTRAL_X:      neutral_x = data[RAW_W-1:0];
                REG_NEUTRAL_Y:      neutral_y = data[RAW_W-1:0];
                REG_INNER_DEADZONE: deadzone  = data[RAW_W-1:0];
                REG_GAIN:           gain      = data[GAIN_W-1:0];
                REG_ACTUATION:      act       = data[ACT_W-1:0];
                REG_ORIENTATION:    orient    = data[1:0];
                REG_STICK_MODE:     mode      = data[1:0];
                default: ;
            endcase
        endfunction

        function longint clamp(longint v);
            if (v < OUT_MIN) return OUT_MIN;
            if (v > OUT_MAX) return OUT_MAX;
            return v;
        endfunction

        function lvl_t level_of(longint v);
            if (v > longint'(act)) return LVL_POS;
            if (v < -longint'(act)) return LVL_NEG;
            return LVL_CENTER;
        endfunction

        function void push_event(kind_t k, longint ax, longint ay, dir_t d, logic arrows);
            stick_event_t ev;
            ev.kind   = k;
            ev.ax     = ax[AXIS_W-1:0];
            ev.ay     = ay[AXIS_W-1:0];
            ev.dir    = d;
            ev.arrows = arrows;
            ev.last   = 1'b0;
            expected_events.push_back(ev);
        endfunction

        // A level change releases the old key first, then presses the new one.
        function void axis_change(lvl_t lvl_now, lvl_t lvl_was, dir_t pos_dir,
                                  dir_t neg_dir, logic arrows);
            if (lvl_now == lvl_was) return;
            if (lvl_was != LVL_CENTER) begin
                push_event(KIND_RELEASE, 0, 0, (lvl_was == LVL_POS) ? pos_dir : neg_dir,
                           arrows);
            end
            if (lvl_now != LVL_CENTER) begin
                push_event(KIND_PRESS, 0, 0, (lvl_now == LVL_POS) ? pos_dir : neg_dir,
                           arrows);
            end
        endfunction

        function void note_sample(logic [RAW_W-1:0] raw_x, logic [RAW_W-1:0] raw_y);
            longint cx;
            longint cy;
            longint dz;
            longint rx;
            longint ry;
            int     first;
            lvl_t   vl;
            lvl_t   hl;
            samples++;
            cx = longint'(raw_x) - longint'(neutral_x);
            cy = longint'(raw_y) - longint'(neutral_y);
            dz = longint'(deadzone);
            if (cx * cx + cy * cy < dz * dz) begin
                cx = 0;
                cy = 0;
            end else begin
                // Signed division truncates toward zero, as the block must.
                cx = clamp((cx * longint'(gain)) / FIXED_SCALE);
                cy = clamp((cy * longint'(gain)) / FIXED_SCALE);
            end
            case (orient)
                ORIENT_RIGHT: begin rx = cy;  ry = -cx; end
                ORIENT_DOWN:  begin rx = -cx; ry = -cy; end
                ORIENT_LEFT:  begin rx = -cy; ry = cx;  end
                default:      begin rx = cx;  ry = cy;  end
            endcase
            rx = clamp(rx);
            ry = clamp(ry);
            if (mode == MODE_ANALOG) begin
                push_event(KIND_AXIS, rx, ry, DIR_UP, 1'b0);
                expected_events[$].last = 1'b1;
                return;
            end
            if (mode != MODE_LETTERS && mode != MODE_ARROWS) return;
            first = expected_events.size();
            vl = level_of(ry);
            hl = level_of(rx);
            axis_change(vl, vert_lvl, DIR_UP, DIR_DOWN, mode == MODE_ARROWS);
            axis_change(hl, horiz_lvl, DIR_RIGHT, DIR_LEFT, mode == MODE_ARROWS);
            vert_lvl  = vl;
            horiz_lvl = hl;
            if (expected_events.size() > first) expected_events[$].last = 1'b1;
        endfunction

        function void check_result(logic [1:0] kind, logic signed [AXIS_W-1:0] ax,
                                   logic signed [AXIS_W-1:0] ay, logic [1:0] dir,
                                   logic arrows, logic last);
            stick_event_t e;
            if (expected_events.size() == 0) begin
                report($sformatf("unexpected result kind=%0d x=%0d y=%0d dir=%0d set=%0b last=%0b",
                                 kind, ax, ay, dir, arrows, last));
                return;
            end
            e = expected_events.pop_front();
            case (e.kind)
                KIND_AXIS:  reports++;
                KIND_PRESS: presses++;
                default:    releases++;
            endcase
            if (kind !== e.kind || ax !== e.ax || ay !== e.ay || dir !== e.dir ||
                arrows !== e.arrows || last !== e.last) begin
                report($sformatf({"expected kind=%0d x=%0d y=%0d dir=%0d set=%0b last=%0b, ",
                                  "got kind=%0d x=%0d y=%0d dir=%0d set=%0b last=%0b"},
                                 e.kind, e.ax, e.ay, e.dir, e.arrows, e.last,
                                 kind, ax, ay, dir, arrows, last));
            end
        endfunction
    endclass

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = REG_NEUTRAL_X;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [RAW_W-1:0]         s_raw_x = '0;
    logic [RAW_W-1:0]         s_raw_y = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [1:0]               m_kind;
    logic signed [AXIS_W-1:0] m_axis_x;
    logic signed [AXIS_W-1:0] m_axis_y;
    logic [1:0]               m_key_dir;
    logic                     m_key_set;
    logic                     m_last;

    stick_scoreboard sb;
    bit              src_stalls = 1'b1;
    bit              sink_stalls = 1'b1;
    bit              hold_req = 1'b0;
    logic [1:0]      cur_mode = MODE_ANALOG;
    int              settings_loaded = 0;

    joystick_deadzone_scale_to_keys_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_raw_x   (s_raw_x),
        .s_raw_y   (s_raw_y),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_kind    (m_kind),
        .m_axis_x  (m_axis_x),
        .m_axis_y  (m_axis_y),
        .m_key_dir (m_key_dir),
        .m_key_set (m_key_set),
        .m_last    (m_last)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Mostly no gap or a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Axis samples cluster at the rails and around the resting value so that
    // key levels get crossed in both directions often.
    function automatic logic [RAW_W-1:0] pick_axis(logic [RAW_W-1:0] neutral);
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 40) return RAW_W'($urandom_range(0, 1023));
        if (r < 60) return RAW_W'($urandom_range(0, 40));
        if (r < 80) return RAW_W'($urandom_range(983, 1023));
        v = int'(neutral) + int'($urandom_range(0, 160)) - 80;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        return RAW_W'(v);
    endfunction

    // All handshakes are sampled here, at the rising edge, before the block
    // updates. Results are checked before the new sample is noted.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                sb.check_result(m_kind, m_axis_x, m_axis_y, m_key_dir, m_key_set, m_last);
            end
            if (s_valid && s_ready) sb.note_sample(s_raw_x, s_raw_y);
            if (cfg_valid && cfg_ready) sb.apply_reg(reg_idx_t'(cfg_index), cfg_data);
        end
    end

    // Result side: random stalls, or one long hold-off on request.
    initial begin : result_sink
        int n;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                n = HOLD_CYCLES;
            end else if (sink_stalls) begin
                n = pick_gap();
            end else begin
                n = 0;
            end
            m_ready = (n == 0);
            if (n > 1) repeat (n - 1) @(negedge aclk);
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, sb.pending());
        $display("joystick_deadzone_scale_to_keys_top_tb failed");
        $finish;
    end

    // The driving tasks start and end at a falling edge.
    task automatic send_sample(input logic [RAW_W-1:0] x, input logic [RAW_W-1:0] y);
        int gap;
        gap = src_stalls ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_raw_x = x;
        s_raw_y = y;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Stop sending, wait for every expected result, then give the block time
    // to finish samples that produce nothing.
    task automatic drain();
        s_valid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic load_settings(input logic [RAW_W-1:0] nx, input logic [RAW_W-1:0] ny,
                                 input logic [RAW_W-1:0] dz, input logic [GAIN_W-1:0] g,
                                 input logic [ACT_W-1:0] act, input orient_t orient,
                                 input logic [1:0] mode);
        drain();
        write_reg(REG_NEUTRAL_X, CFG_DATA_W'(nx));
        write_reg(REG_NEUTRAL_Y, CFG_DATA_W'(ny));
        write_reg(REG_INNER_DEADZONE, CFG_DATA_W'(dz));
        write_reg(REG_GAIN, g);
        write_reg(REG_ACTUATION, CFG_DATA_W'(act));
        write_reg(REG_ORIENTATION, CFG_DATA_W'(orient));
        write_reg(REG_STICK_MODE, CFG_DATA_W'(mode));
        cur_mode = mode;
        settings_loaded++;
    endtask

    initial begin : stimulus
        int               random_items;
        int               phase_len;
        int               r;
        logic [RAW_W-1:0] nx;
        logic [RAW_W-1:0] ny;
        logic [RAW_W-1:0] dz;
        logic [GAIN_W-1:0] g;
        logic [ACT_W-1:0] act;
        logic [1:0]       mode;

        sb = new();
        random_items = 0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn = 1'b1;

        // Reset settings: analog reports at unit gain, rails saturate.
        send_sample(10'd0, 10'd0);
        send_sample(10'd1023, 10'd1023);
        send_sample(10'd512, 10'd512);
        send_sample(10'd639, 10'd385);

        // Extreme neutrals and gain, zero threshold, quarter turn, letter keys.
        load_settings(10'd0, 10'd1023, 10'd0, 16'hFFFF, 7'd0, ORIENT_RIGHT, MODE_LETTERS);
        send_sample(10'd0, 10'd1023);
        send_sample(10'd1023, 10'd0);
        send_sample(10'd1, 10'd1022);
        send_sample(10'd0, 10'd1023);

        // Radial deadzone edge, then direct reversals on one and on both axes.
        load_settings(10'd512, 10'd512, 10'd100, 16'd256, 7'd64, ORIENT_UP, MODE_ARROWS);
        send_sample(10'd572, 10'd591);
        send_sample(10'd572, 10'd592);
        send_sample(10'd1023, 10'd512);
        send_sample(10'd0, 10'd512);
        send_sample(10'd0, 10'd1023);
        send_sample(10'd1023, 10'd0);
        send_sample(10'd512, 10'd512);

        // Keys held under letter mode survive analog mode and are released
        // later under the arrow key set.
        load_settings(10'd512, 10'd512, 10'd0, 16'd256, 7'd64, ORIENT_DOWN, MODE_LETTERS);
        send_sample(10'd1023, 10'd1023);
        load_settings(10'd512, 10'd512, 10'd0, 16'd256, 7'd64, ORIENT_LEFT, MODE_ANALOG);
        send_sample(10'd1023, 10'd0);
        send_sample(10'd0, 10'd512);
        load_settings(10'd512, 10'd512, 10'd0, 16'd128, 7'd127, ORIENT_UP, MODE_ARROWS);
        send_sample(10'd512, 10'd512);
        send_sample(10'd1023, 10'd1023);
        send_sample(10'd0, 10'd0);

        // The unused mode code gives nothing and leaves the key levels alone.
        load_settings(10'd512, 10'd512, 10'd0, 16'd256, 7'd0, ORIENT_UP, MODE_UNUSED);
        send_sample(10'd0, 10'd0);
        send_sample(10'd1023, 10'd1023);

        // Largest deadzone with zero gain: everything collapses to the center.
        load_settings(10'd512, 10'd512, 10'd1023, 16'd0, 7'd64, ORIENT_UP, MODE_ANALOG);
        send_sample(10'd1023, 10'd0);
        send_sample(10'd0, 10'd1023);

        while (random_items < RANDOM_ITEMS) begin
            r  = $urandom_range(0, 99);
            nx = (r < 70) ? RAW_W'($urandom_range(448, 576)) : RAW_W'($urandom_range(0, 1023));
            r  = $urandom_range(0, 99);
            ny = (r < 70) ? RAW_W'($urandom_range(448, 576)) : RAW_W'($urandom_range(0, 1023));
            r  = $urandom_range(0, 99);
            if (r < 40) dz = '0;
            else if (r < 85) dz = RAW_W'($urandom_range(0, 150));
            else if (r < 95) dz = RAW_W'($urandom_range(150, 1023));
            else dz = '1;
            r = $urandom_range(0, 99);
            if (r < 10) g = '0;
            else if (r < 20) g = '1;
            else if (r < 80) g = GAIN_W'($urandom_range(128, 1024));
            else g = GAIN_W'($urandom);
            r = $urandom_range(0, 99);
            if (r < 10) act = '0;
            else if (r < 20) act = '1;
            else act = ACT_W'($urandom_range(0, 127));
            r = $urandom_range(0, 99);
            mode = (r < 6) ? MODE_UNUSED : 2'($urandom_range(0, 2));

            phase_len   = $urandom_range(15, 40);
            src_stalls  = 1'b1;
            sink_stalls = 1'b1;
            if (random_items == 0) begin
                // Back-pressure: the receiver holds off while samples keep
                // coming, so the block must fill up and stall its input.
                mode        = MODE_ANALOG;
                phase_len   = 40;
                src_stalls  = 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                src_stalls  = 1'b0;
                sink_stalls = 1'b0;
            end

            load_settings(nx, ny, dz, g, act, orient_t'($urandom_range(0, 3)), mode);
            if (random_items == 0) hold_req = 1'b1;
            repeat (phase_len) begin
                send_sample(pick_axis(nx), pick_axis(ny));
                if (cur_mode != MODE_UNUSED) random_items++;
            end
        end

        drain();
        $display("Checked %0d samples over %0d register settings:",
                 sb.samples, settings_loaded + 1);
        $display("%0d axis reports, %0d presses, %0d releases.",
                 sb.reports, sb.presses, sb.releases);
        $display("%0d mismatches, %0d results never delivered.", sb.failures, sb.pending());
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("joystick_deadzone_scale_to_keys_top_tb passed");
        end else begin
            $display("joystick_deadzone_scale_to_keys_top_tb failed");
        end
        $finish;
    end

endmodule
